FILE: hdl/stable_ascending_sorter_unit_macros.svh
// assertion macros for the stable ascending sorter
`ifndef STABLE_ASCENDING_SORTER_UNIT_MACROS_SVH
`define STABLE_ASCENDING_SORTER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SASU_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sorter assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SASU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sorter assertion failed");

`endif

FILE: hdl/sasu_pkg.sv
// shared types and constants of the stable ascending sorter
package sasu_pkg;

    localparam int COUNT_W         = 16;
    localparam int POS_W           = 6;
    localparam int MAX_ENTRIES_DEF = 16;

    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [COUNT_W-1:0] count;
    } entry_t;

    typedef struct packed {
        logic accept;
        logic rd_ins;
        logic ins_shift;
        logic ins_place;
        logic rd_emit;
        logic load_out;
        logic out_done;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic in_last;
        logic item_last;
        logic j_zero;
        logic rd_gt;
        logic out_taken;
        logic emit_last;
    } sts_t;

endpackage

FILE: hdl/stable_ascending_sorter_unit.sv
// Stable ascending sorter. Each request on the s_ channel carries one count and
// is tagged with its arrival position; the request with s_batch_end closes the
// batch, after which every stored entry is returned on the m_ channel in
// ascending order of count as position/count pairs, equal counts in arrival
// order. Up to MAX_ENTRIES (2 to 64) entries are kept; later requests of a batch
// are dropped and m_entries_dropped is raised on the final result. Entries are
// insertion-sorted into a single-port entry memory as they arrive; each shift
// step past a stored entry with a larger count is one registered memory read
// and one write, and a final compare is needed when the entry stops behind a
// smaller or equal count. Results are then read from the memory into a register,
// loaded into the output register and held until the sink takes them, one at a
// time. s_ready is low from acceptance until insertion ends and, after a closing
// request, until the final result is taken.
`include "stable_ascending_sorter_unit_macros.svh"

module stable_ascending_sorter_unit #(
    parameter int MAX_ENTRIES = sasu_pkg::MAX_ENTRIES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [sasu_pkg::COUNT_W-1:0] s_case_count,
    input  logic                         s_batch_end,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [sasu_pkg::POS_W-1:0]   m_entry_position,
    output logic [sasu_pkg::COUNT_W-1:0] m_sorted_count,
    output logic                         m_final_result,
    output logic                         m_entries_dropped
);

    sasu_pkg::cmd_t cmd;
    sasu_pkg::sts_t sts;

    sasu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sasu_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_case_count      (s_case_count),
        .s_batch_end       (s_batch_end),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_entry_position  (m_entry_position),
        .m_sorted_count    (m_sorted_count),
        .m_final_result    (m_final_result),
        .m_entries_dropped (m_entries_dropped),
        .cmd               (cmd),
        .sts               (sts)
    );

    // no new request while a result is pending
    `SASU_ASSERT_NOW(a_ready_vs_valid, aclk, aresetn, m_valid, !s_ready)
    // drop flag only on the final result
    `SASU_ASSERT_NOW(a_drop_on_final, aclk, aresetn, m_valid && m_entries_dropped, m_final_result)
    // after the final result is taken the block is ready again
    `SASU_ASSERT_NEXT(a_ready_after_final, aclk, aresetn, m_valid && m_ready && m_final_result, s_ready && !m_valid)
    // at most one memory access command per cycle
    `SASU_ASSERT_NOW(a_one_mem_cmd, aclk, aresetn, 1'b1, $onehot0({cmd.rd_ins, cmd.ins_shift, cmd.ins_place, cmd.rd_emit}))

endmodule

FILE: hdl/sasu_ctrl.sv
// controller state machine of the stable ascending sorter
module sasu_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sasu_pkg::sts_t sts,
    output sasu_pkg::cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_INS_CHK = 6'b000010,
        ST_INS_CMP = 6'b000100,
        ST_EMIT_RD = 6'b001000,
        ST_EMIT_LD = 6'b010000,
        ST_EMIT_OUT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (!sts.full) begin
                        state_next = ST_INS_CHK;
                    end else if (sts.in_last) begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_INS_CHK: begin
                if (sts.j_zero) begin
                    cmd.ins_place = 1'b1;
                    state_next    = sts.item_last ? ST_EMIT_RD : ST_IDLE;
                end else begin
                    cmd.rd_ins = 1'b1;
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                if (sts.rd_gt) begin
                    cmd.ins_shift = 1'b1;
                    state_next    = ST_INS_CHK;
                end else begin
                    cmd.ins_place = 1'b1;
                    state_next    = sts.item_last ? ST_EMIT_RD : ST_IDLE;
                end
            end
            ST_EMIT_RD: begin
                cmd.rd_emit = 1'b1;
                state_next  = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                cmd.load_out = 1'b1;
                state_next   = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (sts.out_taken) begin
                    cmd.out_done = 1'b1;
                    state_next   = sts.emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/sasu_dp.sv
// datapath of the stable ascending sorter: entry memory, counters and result register
module sasu_dp #(
    parameter int MAX_ENTRIES = sasu_pkg::MAX_ENTRIES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [sasu_pkg::COUNT_W-1:0] s_case_count,
    input  logic                         s_batch_end,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [sasu_pkg::POS_W-1:0]   m_entry_position,
    output logic [sasu_pkg::COUNT_W-1:0] m_sorted_count,
    output logic                         m_final_result,
    output logic                         m_entries_dropped,
    input  sasu_pkg::cmd_t               cmd,
    output sasu_pkg::sts_t               sts
);

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int FILL_W = $clog2(MAX_ENTRIES + 1);

    sasu_pkg::entry_t mem [MAX_ENTRIES];
    sasu_pkg::entry_t rd_data_reg;

    logic [FILL_W-1:0]            fill_reg;
    logic                         ovf_reg;
    logic [sasu_pkg::COUNT_W-1:0] item_count_reg;
    logic                         item_last_reg;
    logic [IDX_W-1:0]             j_reg;
    logic [IDX_W-1:0]             k_reg;
    logic                         out_valid_reg;
    sasu_pkg::entry_t             out_entry_reg;
    logic                         out_final_reg;
    logic                         out_drop_reg;

    logic [IDX_W-1:0]   rd_addr;
    sasu_pkg::entry_t   new_entry;

    assign rd_addr   = cmd.rd_emit ? k_reg : IDX_W'(j_reg - 1'b1);
    assign new_entry = '{pos: sasu_pkg::POS_W'(fill_reg), count: item_count_reg};

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.ins_shift) begin
            mem[j_reg] <= rd_data_reg;
        end else if (cmd.ins_place) begin
            mem[j_reg] <= new_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_ins || cmd.rd_emit) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.accept && sts.full) begin
                ovf_reg <= 1'b1;
            end
            if (cmd.ins_place) begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end
            if (cmd.out_done) begin
                out_valid_reg <= 1'b0;
                if (sts.emit_last) begin
                    fill_reg <= '0;
                    ovf_reg  <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_count_reg <= s_case_count;
            item_last_reg  <= s_batch_end;
            j_reg          <= IDX_W'(fill_reg);
            k_reg          <= '0;
        end
        if (cmd.ins_shift) begin
            j_reg <= IDX_W'(j_reg - 1'b1);
        end
        if (cmd.out_done) begin
            k_reg <= IDX_W'(k_reg + 1'b1);
        end
        if (cmd.load_out) begin
            out_entry_reg <= rd_data_reg;
            out_final_reg <= sts.emit_last;
            out_drop_reg  <= sts.emit_last & ovf_reg;
        end
    end

    always_comb begin
        sts.full      = (fill_reg == FILL_W'(MAX_ENTRIES));
        sts.in_last   = s_batch_end;
        sts.item_last = item_last_reg;
        sts.j_zero    = (j_reg == '0);
        sts.rd_gt     = (rd_data_reg.count > item_count_reg);
        sts.out_taken = out_valid_reg & m_ready;
        sts.emit_last = ((FILL_W'(k_reg) + FILL_W'(1)) == fill_reg);
    end

    assign m_valid           = out_valid_reg;
    assign m_entry_position  = out_entry_reg.pos;
    assign m_sorted_count    = out_entry_reg.count;
    assign m_final_result    = out_final_reg;
    assign m_entries_dropped = out_drop_reg;

endmodule

FILE: bench/tb_stable_ascending_sorter_unit.sv
// self-checking testbench for the stable ascending sorter unit
module tb_stable_ascending_sorter_unit;

    localparam int SORT_DEPTH   = sasu_pkg::MAX_ENTRIES_DEF;
    localparam int HOLD_AT      = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 140;

    typedef enum {SENDER_LIGHT, SENDER_HEAVY, FULL_RATE} traffic_phase_t;
    typedef enum {ANY_COUNT, FEW_VALUES, EDGE_VALUES} count_style_t;

    typedef struct packed {
        logic [sasu_pkg::COUNT_W-1:0] count;
        logic                         closing;
    } sort_request_t;

    typedef struct packed {
        logic [sasu_pkg::POS_W-1:0]   position;
        logic [sasu_pkg::COUNT_W-1:0] count;
        logic                         final_flag;
        logic                         dropped_flag;
    } sorted_entry_t;

    logic                         aclk              = 1'b0;
    logic                         aresetn           = 1'b0;
    logic                         s_valid           = 1'b0;
    logic                         s_ready;
    logic [sasu_pkg::COUNT_W-1:0] s_case_count      = '0;
    logic                         s_batch_end       = 1'b0;
    logic                         m_valid;
    logic                         m_ready           = 1'b0;
    logic [sasu_pkg::POS_W-1:0]   m_entry_position;
    logic [sasu_pkg::COUNT_W-1:0] m_sorted_count;
    logic                         m_final_result;
    logic                         m_entries_dropped;

    sort_request_t pending_requests [$];
    sorted_entry_t sorted_expect [$];

    logic [sasu_pkg::COUNT_W-1:0] batch_counts [SORT_DEPTH];
    int unsigned                  batch_fill     = 0;
    bit                           batch_overflow = 1'b0;

    int requests_taken = 0;
    int total_requests = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int hold_left      = 0;
    bit hold_taken     = 1'b0;

    stable_ascending_sorter_unit #(
        .MAX_ENTRIES(SORT_DEPTH)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_case_count     (s_case_count),
        .s_batch_end      (s_batch_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_entry_position (m_entry_position),
        .m_sorted_count   (m_sorted_count),
        .m_final_result   (m_final_result),
        .m_entries_dropped(m_entries_dropped)
    );

    always #6 aclk = ~aclk;

    function automatic traffic_phase_t phase_now();
        if (requests_taken < total_requests / 3) return SENDER_LIGHT;
        if (requests_taken < 2 * total_requests / 3) return SENDER_HEAVY;
        return FULL_RATE;
    endfunction

    function automatic int sender_idle_pct();
        case (phase_now())
            SENDER_LIGHT: return 37;
            SENDER_HEAVY: return 65;
            default:      return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct();
        case (phase_now())
            SENDER_LIGHT: return 65;
            SENDER_HEAVY: return 37;
            default:      return 0;
        endcase
    endfunction

    // store the count, and on a closing request emit the batch in stable order
    task automatic absorb_request(input logic [sasu_pkg::COUNT_W-1:0] count,
                                  input logic closing);
        int unsigned   order [SORT_DEPTH];
        int unsigned   key;
        int unsigned   j;
        sorted_entry_t entry;
        if (batch_fill < SORT_DEPTH) begin
            batch_counts[batch_fill] = count;
            batch_fill++;
        end else begin
            batch_overflow = 1'b1;
        end
        if (closing) begin
            for (int unsigned i = 0; i < batch_fill; i++) begin
                key = i;
                j   = i;
                while (j > 0 && batch_counts[order[j-1]] > batch_counts[key]) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = key;
            end
            for (int unsigned k = 0; k < batch_fill; k++) begin
                entry.position     = sasu_pkg::POS_W'(order[k]);
                entry.count        = batch_counts[order[k]];
                entry.final_flag   = (k + 1 == batch_fill);
                entry.dropped_flag = entry.final_flag && batch_overflow;
                sorted_expect.push_back(entry);
            end
            batch_fill     = 0;
            batch_overflow = 1'b0;
        end
    endtask

    task automatic report_field(input string field, input int unsigned want,
                                input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    function automatic logic [sasu_pkg::COUNT_W-1:0] pick_count(input count_style_t style);
        logic [sasu_pkg::COUNT_W-1:0] edges [6] = '{16'h0000, 16'h0001, 16'h7FFF,
                                                    16'h8000, 16'hFFFE, 16'hFFFF};
        case (style)
            FEW_VALUES:  return sasu_pkg::COUNT_W'($urandom_range(3));
            EDGE_VALUES: return edges[$urandom_range(5)];
            default:     return sasu_pkg::COUNT_W'($urandom);
        endcase
    endfunction

    task automatic queue_request(input logic [sasu_pkg::COUNT_W-1:0] count,
                                 input logic closing);
        sort_request_t req;
        req.count   = count;
        req.closing = closing;
        pending_requests.push_back(req);
    endtask

    task automatic queue_random_batch(input int unsigned len);
        count_style_t style;
        style = count_style_t'($urandom_range(2));
        for (int unsigned i = 0; i < len; i++)
            queue_request(pick_count(style), i + 1 == len);
    endtask

    always @(posedge aclk) begin : request_driver
        sort_request_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_request(s_case_count, s_batch_end);
                requests_taken <= requests_taken + 1;
            end
            if (!s_valid || s_ready) begin
                if (pending_requests.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct()) begin
                    nxt = pending_requests.pop_front();
                    s_valid      <= 1'b1;
                    s_case_count <= nxt.count;
                    s_batch_end  <= nxt.closing;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        sorted_entry_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (sorted_expect.size() == 0) begin
                    $display("%0t: unexpected result expected none actual pos %0d count %0d",
                             $time, m_entry_position, m_sorted_count);
                    mismatch_count++;
                end else begin
                    want = sorted_expect.pop_front();
                    report_field("entry_position", want.position, m_entry_position);
                    report_field("sorted_count", want.count, m_sorted_count);
                    report_field("final_result", want.final_flag, m_final_result);
                    report_field("entries_dropped", want.dropped_flag, m_entries_dropped);
                end
            end
            // long sink stall so the block fills and backs up its input
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (!hold_taken && requests_taken >= HOLD_AT) begin
                hold_taken <= 1'b1;
                hold_left  <= HOLD_CYCLES;
                m_ready    <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= receiver_idle_pct());
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned random_items;
        int unsigned len;
        random_items = 0;

        // single-entry batches at both extremes
        queue_request(16'hFFFF, 1'b1);
        queue_request(16'h0000, 1'b1);
        // ties keep arrival order
        queue_request(16'd7, 1'b0);
        queue_request(16'd7, 1'b0);
        queue_request(16'd3, 1'b0);
        queue_request(16'hFFFF, 1'b0);
        queue_request(16'h0000, 1'b0);
        queue_request(16'd7, 1'b0);
        queue_request(16'd3, 1'b1);
        // store full, closing request dropped
        for (int i = 0; i <= SORT_DEPTH; i++)
            queue_request(sasu_pkg::COUNT_W'((SORT_DEPTH + 1 - i) * 3000), i == SORT_DEPTH);

        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(9) == 0)
                len = $urandom_range(SORT_DEPTH + 4, SORT_DEPTH + 1);
            else
                len = $urandom_range(SORT_DEPTH, 1);
            queue_random_batch(len);
            random_items += len;
        end
        total_requests = pending_requests.size();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() != 0 || s_valid) @(posedge aclk);
        while (sorted_expect.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sorted_expect.size() != 0) begin
            $display("%0t: %0d results expected actual none", $time, sorted_expect.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
